### hw/rtl/sms_pkg.sv
package sms_pkg;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_WORD,
		CMD_SELECT,
		CMD_RELEASE
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SEL_WORD,
		PH_SEL_ONLY,
		PH_SETTLE,
		PH_ACTIVE,
		PH_RECOVER
	} phase_t;

	typedef struct packed {
		cmd_t cmd;
		logic begin_frame;
		logic end_frame;
		logic miso;
	} ctl_t;

	typedef struct packed {
		logic       clock_idle_high;
		logic       select_active_low;
		logic [7:0] half_period;
		logic [7:0] data_settle;
		logic [7:0] select_settle;
	} cfg_t;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 8;
	localparam int RX_BITS        = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOCK_IDLE_HIGH   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SELECT_ACTIVE_LOW = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_PERIOD       = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DATA_SETTLE       = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SELECT_SETTLE     = 3'd4;

	localparam logic [7:0] DELAY_RESET = 8'd50;

	function automatic logic [7:0] at_least_one(logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

endpackage

### hw/rtl/sms_queue.sv
module sms_queue #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = (count_q == 2'd2);
	assign not_empty = (count_q != 2'd0);
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

### hw/rtl/sms_front.sv
module sms_front #(
	parameter int DATA_BITS = 8
) (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 byte_valid,
	input  logic [7:0]           tx_byte,
	input  logic                 begin_frame,
	input  logic                 end_frame,
	input  logic                 miso_level,
	input  logic                 queue_full,
	output logic                 push,
	output sms_pkg::ctl_t        ctl,
	output logic [DATA_BITS-1:0] word
);

	logic [DATA_BITS+7:0] wide_byte;

	assign in_ready  = !queue_full;
	assign push      = in_valid && !queue_full;
	assign wide_byte = {{DATA_BITS{1'b0}}, tx_byte};
	assign word      = wide_byte[DATA_BITS-1:0];

	always_comb begin
		ctl.begin_frame = begin_frame;
		ctl.end_frame   = end_frame;
		ctl.miso        = miso_level;
		if (byte_valid) begin
			ctl.cmd = sms_pkg::CMD_WORD;
		end else if (begin_frame) begin
			ctl.cmd = sms_pkg::CMD_SELECT;
		end else if (end_frame) begin
			ctl.cmd = sms_pkg::CMD_RELEASE;
		end else begin
			ctl.cmd = sms_pkg::CMD_NONE;
		end
	end

endmodule

### hw/rtl/sms_back.sv
module sms_back #(
	parameter int DATA_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sms_pkg::cfg_t        cfg,
	input  logic                 item_valid,
	input  sms_pkg::ctl_t        ctl,
	input  logic [DATA_BITS-1:0] word,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 sclk_level,
	output logic                 mosi_level,
	output logic                 select_level,
	output logic                 ready_res,
	output logic                 rx_valid,
	output logic [7:0]           rx_byte
);

	localparam int CW = $clog2(DATA_BITS);
	localparam logic [CW-1:0] LAST_BIT = CW'(DATA_BITS - 1);

	sms_pkg::phase_t      phase_q, phase_d;
	logic [CW-1:0]        bit_q, bit_d;
	logic [DATA_BITS-1:0] tx_q, tx_d;
	logic [DATA_BITS-1:0] rx_q, rx_d;
	logic [7:0]           wait_q, wait_d, wait_dec;
	logic                 sel_q, sel_d;
	logic                 rel_q, rel_d;
	logic                 mosi_q, mosi_d;
	logic                 expired, done;
	logic [DATA_BITS+7:0] rx_wide;

	logic       sclk_d, select_d, ready_d, rxv_d;
	logic [7:0] rxb_d;

	logic       out_valid_q, sclk_q, mosi_out_q, select_q, ready_q, rxv_q;
	logic [7:0] rxb_q;

	assign pop      = item_valid && (!out_valid_q || out_ready);
	assign wait_dec = wait_q - 8'd1;
	assign expired  = (phase_q != sms_pkg::PH_IDLE) && (wait_dec == 8'd0);

	always_comb begin
		phase_d = phase_q;
		bit_d   = bit_q;
		tx_d    = tx_q;
		rx_d    = rx_q;
		wait_d  = (phase_q != sms_pkg::PH_IDLE) ? wait_dec : wait_q;
		sel_d   = sel_q;
		rel_d   = rel_q;
		mosi_d  = mosi_q;
		done    = 1'b0;
		case (phase_q)
			sms_pkg::PH_IDLE: begin
				case (ctl.cmd)
					sms_pkg::CMD_WORD: begin
						tx_d  = word;
						rx_d  = '0;
						bit_d = '0;
						rel_d = ctl.end_frame;
						if (ctl.begin_frame) begin
							sel_d   = 1'b1;
							phase_d = sms_pkg::PH_SEL_WORD;
							wait_d  = sms_pkg::at_least_one(cfg.select_settle);
						end else begin
							mosi_d  = word[DATA_BITS-1];
							phase_d = sms_pkg::PH_SETTLE;
							wait_d  = sms_pkg::at_least_one(cfg.data_settle);
						end
					end
					sms_pkg::CMD_SELECT: begin
						sel_d   = 1'b1;
						rel_d   = ctl.end_frame;
						phase_d = sms_pkg::PH_SEL_ONLY;
						wait_d  = sms_pkg::at_least_one(cfg.select_settle);
					end
					sms_pkg::CMD_RELEASE: begin
						sel_d = 1'b0;
					end
					default: begin
					end
				endcase
			end
			sms_pkg::PH_SEL_WORD: begin
				if (expired) begin
					mosi_d  = tx_q[DATA_BITS-1];
					phase_d = sms_pkg::PH_SETTLE;
					wait_d  = sms_pkg::at_least_one(cfg.data_settle);
				end
			end
			sms_pkg::PH_SEL_ONLY: begin
				if (expired) begin
					if (rel_q) begin
						sel_d = 1'b0;
					end
					rel_d   = 1'b0;
					phase_d = sms_pkg::PH_IDLE;
				end
			end
			sms_pkg::PH_SETTLE: begin
				if (expired) begin
					phase_d = sms_pkg::PH_ACTIVE;
					wait_d  = sms_pkg::at_least_one(cfg.half_period);
				end
			end
			sms_pkg::PH_ACTIVE: begin
				if (expired) begin
					rx_d    = {rx_q[DATA_BITS-2:0], ctl.miso};
					phase_d = sms_pkg::PH_RECOVER;
					wait_d  = sms_pkg::at_least_one(cfg.half_period);
				end
			end
			sms_pkg::PH_RECOVER: begin
				if (expired) begin
					if (bit_q == LAST_BIT) begin
						done = 1'b1;
						if (rel_q) begin
							sel_d = 1'b0;
						end
						rel_d   = 1'b0;
						bit_d   = '0;
						phase_d = sms_pkg::PH_IDLE;
					end else begin
						bit_d   = bit_q + CW'(1);
						tx_d    = {tx_q[DATA_BITS-2:0], 1'b0};
						mosi_d  = tx_q[DATA_BITS-2];
						phase_d = sms_pkg::PH_SETTLE;
						wait_d  = sms_pkg::at_least_one(cfg.data_settle);
					end
				end
			end
			default: begin
				phase_d = sms_pkg::PH_IDLE;
			end
		endcase
	end

	assign rx_wide = {8'd0, rx_q};

	always_comb begin
		sclk_d   = (phase_d == sms_pkg::PH_ACTIVE) ^ cfg.clock_idle_high;
		select_d = sel_d ^ cfg.select_active_low;
		ready_d  = (phase_d == sms_pkg::PH_IDLE);
		rxv_d    = done;
		rxb_d    = done ? rx_wide[7:0] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= sms_pkg::PH_IDLE;
			bit_q       <= '0;
			tx_q        <= '0;
			rx_q        <= '0;
			wait_q      <= 8'd0;
			sel_q       <= 1'b0;
			rel_q       <= 1'b0;
			mosi_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				bit_q   <= bit_d;
				tx_q    <= tx_d;
				rx_q    <= rx_d;
				wait_q  <= wait_d;
				sel_q   <= sel_d;
				rel_q   <= rel_d;
				mosi_q  <= mosi_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sclk_q     <= sclk_d;
			mosi_out_q <= mosi_d;
			select_q   <= select_d;
			ready_q    <= ready_d;
			rxv_q      <= rxv_d;
			rxb_q      <= rxb_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign sclk_level   = sclk_q;
	assign mosi_level   = mosi_out_q;
	assign select_level = select_q;
	assign ready_res    = ready_q;
	assign rx_valid     = rxv_q;
	assign rx_byte      = rxb_q;

endmodule

### hw/rtl/spi_master_byte_shifter_core.sv
// Channel  Handshake               Word
// in       in_valid / in_ready     byte_valid, tx_byte, begin_frame, end_frame, miso_level
// out      out_valid / out_ready   sclk_level, mosi_level, select_level, ready_res, rx_valid, rx_byte
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One input word is one tick of pin timing and yields one output word.
// The block takes one word per cycle while the queue is not full; a two-entry queue
// feeds the shifter, and each word passes through the queue and then the output register.
// Reset clears the shifter, queue and output valid flag and loads the default
// configuration. A stall on the output holds the queue, and a full queue
// drops in_ready. Configuration writes are always taken.
module spi_master_byte_shifter_core #(
	parameter int DATA_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               byte_valid,
	input  logic [7:0]                         tx_byte,
	input  logic                               begin_frame,
	input  logic                               end_frame,
	input  logic                               miso_level,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               sclk_level,
	output logic                               mosi_level,
	output logic                               select_level,
	output logic                               ready_res,
	output logic                               rx_valid,
	output logic [7:0]                         rx_byte,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [sms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int QW = $bits(sms_pkg::ctl_t) + DATA_BITS;

	sms_pkg::cfg_t        cfg_q;
	sms_pkg::ctl_t        front_ctl, back_ctl;
	logic [DATA_BITS-1:0] front_word, back_word;
	logic                 push, pop, queue_full, queue_not_empty;
	logic [QW-1:0]        queue_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clock_idle_high   <= 1'b0;
			cfg_q.select_active_low <= 1'b0;
			cfg_q.half_period       <= sms_pkg::DELAY_RESET;
			cfg_q.data_settle       <= sms_pkg::DELAY_RESET;
			cfg_q.select_settle     <= sms_pkg::DELAY_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				sms_pkg::CFG_CLOCK_IDLE_HIGH:   cfg_q.clock_idle_high   <= cfg_data[0];
				sms_pkg::CFG_SELECT_ACTIVE_LOW: cfg_q.select_active_low <= cfg_data[0];
				sms_pkg::CFG_HALF_PERIOD:       cfg_q.half_period       <= cfg_data;
				sms_pkg::CFG_DATA_SETTLE:       cfg_q.data_settle       <= cfg_data;
				sms_pkg::CFG_SELECT_SETTLE:     cfg_q.select_settle     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	sms_front #(
		.DATA_BITS(DATA_BITS)
	) u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_valid (byte_valid),
		.tx_byte    (tx_byte),
		.begin_frame(begin_frame),
		.end_frame  (end_frame),
		.miso_level (miso_level),
		.queue_full (queue_full),
		.push       (push),
		.ctl        (front_ctl),
		.word       (front_word)
	);

	sms_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({front_ctl, front_word}),
		.pop      (pop),
		.full     (queue_full),
		.not_empty(queue_not_empty),
		.pop_data (queue_out)
	);

	assign back_ctl  = queue_out[QW-1:DATA_BITS];
	assign back_word = queue_out[DATA_BITS-1:0];

	sms_back #(
		.DATA_BITS(DATA_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.item_valid  (queue_not_empty),
		.ctl         (back_ctl),
		.word        (back_word),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sclk_level  (sclk_level),
		.mosi_level  (mosi_level),
		.select_level(select_level),
		.ready_res   (ready_res),
		.rx_valid    (rx_valid),
		.rx_byte     (rx_byte)
	);

	// A completed word always returns the shifter to idle.
	a_rx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && rx_valid) |-> ready_res)
		else $error("received word without return to idle");

	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !rx_valid) |-> (rx_byte == 8'd0))
		else $error("rx_byte nonzero outside a completed word");

	a_idle_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ready_res) |-> (sclk_level == cfg_q.clock_idle_high))
		else $error("serial clock not at idle level while idle");

	a_pop_source: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> queue_not_empty)
		else $error("shifter took a word from an empty queue");

endmodule
